### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg
// Types, constants and helpers for the image difference statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package ids_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 4096;
  localparam int DEFAULT_MAX_HEIGHT = 4096;

  localparam int CFG_DATA_W = 50;
  localparam int CFG_INDEX_W = 3;
  localparam int DIFF_W = 42;
  localparam int STAT_W = 50;
  localparam int CNT_W = 27;
  localparam int SUM_W = 64;
  localparam int QUOT_W = 80;
  localparam int ROOT_W = 40;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FORMAT     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TOL    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MEAN_TOL   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RMSE_TOL   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_OUTLIER = 3'd6;

  // Channel formats
  localparam logic [1:0] FMT_GRAY8 = 2'd0;
  localparam logic [1:0] FMT_RGBA8 = 2'd1;
  localparam logic [1:0] FMT_HALF  = 2'd2;

  localparam logic [4:0] HALF_EXP_MAX = 5'h1F;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_MUL,
    ST_ACC,
    ST_START,
    ST_CALC,
    ST_LOAD
  } ids_state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MEAN,
    PH_RMS,
    PH_ROOT
  } ids_phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ids_calc_stat_t;

  function automatic logic half_finite(input logic [15:0] h);
    return h[14:10] != HALF_EXP_MAX;
  endfunction

  // Exact half to signed fixed point with 24 fraction bits; zero if non-finite.
  function automatic logic signed [DIFF_W-1:0] half_to_fixed(input logic [15:0] h);
    logic [4:0] e;
    logic [DIFF_W-2:0] mag;
    logic signed [DIFF_W-1:0] v;
    e = h[14:10];
    if (e == HALF_EXP_MAX) begin
      mag = '0;
    end else if (e == 5'd0) begin
      mag = (DIFF_W-1)'(h[9:0]);
    end else begin
      mag = (DIFF_W-1)'({1'b1, h[9:0]}) << (e - 5'd1);
    end
    v = $signed({1'b0, mag});
    return h[15] ? -v : v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ids_calc.sv
// ----------------------------------------------------------------------------
// ids_calc
// Mean and RMS sequencer: two restoring divisions and one integer square
// root, all through one shared subtractor, one bit or one root digit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ids_calc #(
  parameter int NW = 27
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ids_pkg::SUM_W-1:0] abs_sum,
  input  wire logic [ids_pkg::SUM_W-1:0] square_sum,
  input  wire logic [NW-1:0]             count,
  output ids_pkg::ids_calc_stat_t        stat,
  output logic [ids_pkg::STAT_W-1:0]     mean_value,
  output logic [ids_pkg::STAT_W-1:0]     rms_value
);
  import ids_pkg::*;

  localparam int SW = (NW + 1 > ROOT_W + 4) ? NW + 1 : ROOT_W + 4;

  ids_phase_t         phase;
  logic               done;
  logic [QUOT_W-1:0]  dq;
  logic [SW-1:0]      rem;
  logic [ROOT_W-1:0]  root;
  logic [6:0]         step;
  logic [SW-1:0]      op_a;
  logic [SW-1:0]      op_b;
  logic [SW:0]        diff;
  logic               take;
  logic [QUOT_W-1:0]  quot;

  // Shared subtractor
  always_comb begin
    if (phase == PH_ROOT) begin
      op_a = SW'({rem[ROOT_W+1:0], dq[QUOT_W-1:QUOT_W-2]});
      op_b = SW'({root, 2'b01});
    end else begin
      op_a = SW'({rem[NW-1:0], dq[QUOT_W-1]});
      op_b = SW'(count);
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    take = !diff[SW];
    quot = {dq[QUOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_MEAN;
            dq    <= {abs_sum, 16'd0};
            rem   <= '0;
            step  <= 7'(QUOT_W - 1);
          end
        end
        PH_MEAN: begin
          rem  <= take ? diff[SW-1:0] : op_a;
          dq   <= quot;
          step <= step - 7'd1;
          if (step == 7'd0) begin
            // Quotient is 2^16 * sum / n; drop 8 bits and cap.
            mean_value <= (|quot[QUOT_W-1:STAT_W+8]) ? '1 : quot[STAT_W+7:8];
            phase <= PH_RMS;
            dq    <= {square_sum, 16'd0};
            rem   <= '0;
            step  <= 7'(QUOT_W - 1);
          end
        end
        PH_RMS: begin
          rem  <= take ? diff[SW-1:0] : op_a;
          dq   <= quot;
          step <= step - 7'd1;
          if (step == 7'd0) begin
            phase <= PH_ROOT;
            rem   <= '0;
            root  <= '0;
            step  <= 7'(ROOT_W - 1);
          end
        end
        PH_ROOT: begin
          rem  <= take ? diff[SW-1:0] : op_a;
          root <= {root[ROOT_W-2:0], take};
          dq   <= {dq[QUOT_W-3:0], 2'b00};
          step <= step - 7'd1;
          if (step == 7'd0) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  assign rms_value = STAT_W'(root);
  assign stat.busy = phase != PH_IDLE;
  assign stat.done = done;

endmodule

`default_nettype wire

### hw/rtl/image_difference_statistics.sv
// ----------------------------------------------------------------------------
// image_difference_statistics
// Compares a reference and a measured image one channel word at a time.
// ----------------------------------------------------------------------------
// Each channel word is captured, converted and differenced, squared on one
// 32x32 multiplier and accumulated in turn; in_stall is high meanwhile. After the
// last word of an image the mean and RMS are worked out by one shared
// subtractor in two divisions and a square root, skipped when every channel
// was non-finite. The result word is then loaded once no pending word is
// held by out_stall; a pending word does not block the next image's input.
`default_nettype none
`include "assert_macros.svh"

module image_difference_statistics #(
  parameter int MAX_WIDTH  = ids_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = ids_pkg::DEFAULT_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [ids_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ids_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [15:0]                    reference_value,
  input  wire logic [15:0]                    measured_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [ids_pkg::DIFF_W-1:0]          largest_difference,
  output logic [11:0]                         worst_column,
  output logic [11:0]                         worst_row,
  output logic [1:0]                          worst_lane,
  output logic [ids_pkg::CNT_W-1:0]           outlier_total,
  output logic [ids_pkg::CNT_W-1:0]           nonfinite_total,
  output logic [ids_pkg::CNT_W-1:0]           channel_total,
  output logic [ids_pkg::STAT_W-1:0]          mean_difference,
  output logic [ids_pkg::STAT_W-1:0]          rms_difference,
  output logic                                within_tolerance
);
  import ids_pkg::*;

  localparam int CW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
  localparam int RW = ($clog2(MAX_HEIGHT + 1) > 12) ? $clog2(MAX_HEIGHT + 1) : 12;
  localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT * 4 + 1);

  // Configuration
  logic [1:0]         channel_format;
  logic [12:0]        image_width;
  logic [12:0]        image_height;
  logic [DIFF_W-1:0]  max_abs_tolerance;
  logic [STAT_W-1:0]  mean_abs_tolerance;
  logic [STAT_W-1:0]  rmse_tolerance;
  logic [CNT_W-1:0]   max_outlier_count;

  // Per-word datapath
  ids_state_t         state;
  ids_state_t         state_next;
  logic [15:0]        ref_q;
  logic [15:0]        meas_q;
  logic [DIFF_W-1:0]  diff_q;
  logic               nonfin_q;
  logic [SUM_W-1:0]   sq_q;

  // Image state
  logic [TW-1:0]      position_count;
  logic [CW-1:0]      column_count;
  logic [RW-1:0]      row_count;
  logic [1:0]         lane_count;
  logic [SUM_W-1:0]   abs_sum;
  logic [SUM_W-1:0]   square_sum;
  logic [DIFF_W-1:0]  best_difference;
  logic [CW-1:0]      best_column;
  logic [RW-1:0]      best_row;
  logic [1:0]         best_lane;
  logic [TW-1:0]      outlier_count;
  logic [TW-1:0]      nonfinite_count;

  logic [CW-1:0]      w_eff;
  logic [RW-1:0]      h_eff;
  logic [TW-1:0]      area;
  logic [TW-1:0]      total_q;
  logic               four_lanes;
  logic               half_fmt;
  logic [TW-1:0]      pos_inc;
  logic [2:0]         lane_inc;
  logic [CW:0]        col_inc;
  logic [TW-1:0]      finite_n;
  logic               image_end;
  logic               load;
  logic               calc_start;
  logic               clear_image;
  logic [SUM_W:0]     abs_ext;
  logic [SUM_W:0]     sq_ext;
  logic signed [DIFF_W-1:0] ref_fix;
  logic signed [DIFF_W-1:0] meas_fix;
  logic signed [DIFF_W-1:0] delta;
  logic               conv_finite;
  ids_calc_stat_t     calc_stat;
  logic [STAT_W-1:0]  calc_mean;
  logic [STAT_W-1:0]  calc_rms;
  logic [STAT_W-1:0]  mean_sel;
  logic [STAT_W-1:0]  rms_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_format     <= FMT_RGBA8;
      image_width        <= 13'd1;
      image_height       <= 13'd1;
      max_abs_tolerance  <= DIFF_W'(2);
      mean_abs_tolerance <= STAT_W'(128);
      rmse_tolerance     <= STAT_W'(256);
      max_outlier_count  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FORMAT:      channel_format     <= cfg_data[1:0];
        REG_WIDTH:       image_width        <= cfg_data[12:0];
        REG_HEIGHT:      image_height       <= cfg_data[12:0];
        REG_MAX_TOL:     max_abs_tolerance  <= cfg_data[DIFF_W-1:0];
        REG_MEAN_TOL:    mean_abs_tolerance <= cfg_data;
        REG_RMSE_TOL:    rmse_tolerance     <= cfg_data;
        REG_MAX_OUTLIER: max_outlier_count  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign four_lanes = channel_format != FMT_GRAY8;
  assign half_fmt   = channel_format == FMT_HALF;

  // Clamp the image size
  always_comb begin
    if (image_width == 13'd0) begin
      w_eff = CW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(image_width);
    end
    if (image_height == 13'd0) begin
      h_eff = RW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(image_height);
    end
    area = TW'(w_eff) * TW'(h_eff);
  end

  always_ff @(posedge clk) begin
    total_q <= four_lanes ? (area << 2) : area;
  end

  // Convert and difference
  always_comb begin
    if (half_fmt) begin
      ref_fix     = half_to_fixed(ref_q);
      meas_fix    = half_to_fixed(meas_q);
      conv_finite = half_finite(ref_q) && half_finite(meas_q);
    end else begin
      ref_fix     = $signed(DIFF_W'(ref_q[7:0]));
      meas_fix    = $signed(DIFF_W'(meas_q[7:0]));
      conv_finite = 1'b1;
    end
    delta = ref_fix - meas_fix;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      ref_q  <= reference_value;
      meas_q <= measured_value;
    end
    if (state == ST_CONV) begin
      diff_q   <= delta[DIFF_W-1] ? DIFF_W'(-delta) : DIFF_W'(delta);
      nonfin_q <= !conv_finite;
    end
    if (state == ST_MUL) begin
      // Squares of differences at or above 2^32 saturate
      sq_q <= (|diff_q[DIFF_W-1:32]) ? '1 : diff_q[31:0] * diff_q[31:0];
    end
  end

  assign pos_inc   = position_count + TW'(1);
  assign lane_inc  = {1'b0, lane_count} + 3'd1;
  assign col_inc   = {1'b0, column_count} + (CW+1)'(1);
  assign abs_ext   = {1'b0, abs_sum} + (SUM_W+1)'(diff_q);
  assign sq_ext    = {1'b0, square_sum} + {1'b0, sq_q};
  assign image_end = pos_inc >= total_q;
  assign finite_n  = position_count - nonfinite_count;

  // Accumulate
  always_ff @(posedge clk) begin
    if (rst || clear_image) begin
      position_count  <= '0;
      column_count    <= '0;
      row_count       <= '0;
      lane_count      <= '0;
      abs_sum         <= '0;
      square_sum      <= '0;
      best_difference <= '0;
      best_column     <= '0;
      best_row        <= '0;
      best_lane       <= '0;
      outlier_count   <= '0;
      nonfinite_count <= '0;
    end else if (state == ST_ACC) begin
      if (nonfin_q) begin
        nonfinite_count <= nonfinite_count + TW'(1);
      end else begin
        abs_sum    <= abs_ext[SUM_W] ? '1 : abs_ext[SUM_W-1:0];
        square_sum <= sq_ext[SUM_W] ? '1 : sq_ext[SUM_W-1:0];
        if (diff_q > max_abs_tolerance) begin
          outlier_count <= outlier_count + TW'(1);
        end
        if (diff_q > best_difference) begin
          best_difference <= diff_q;
          best_column     <= column_count;
          best_row        <= row_count;
          best_lane       <= lane_count;
        end
      end
      position_count <= pos_inc;
      if (lane_inc >= (four_lanes ? 3'd4 : 3'd1)) begin
        lane_count <= '0;
        if (col_inc >= {1'b0, w_eff}) begin
          column_count <= '0;
          row_count    <= row_count + RW'(1);
        end else begin
          column_count <= col_inc[CW-1:0];
        end
      end else begin
        lane_count <= lane_inc[1:0];
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    calc_start  = 1'b0;
    load        = 1'b0;
    clear_image = 1'b0;
    in_stall    = state != ST_IDLE;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CONV;
      ST_CONV:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_ACC;
      ST_ACC:   state_next = image_end ? ST_START : ST_IDLE;
      ST_START: begin
        // Skip the divider when every channel was non-finite
        if (finite_n == '0) begin
          state_next = ST_LOAD;
        end else begin
          calc_start = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC:  if (calc_stat.done) state_next = ST_LOAD;
      ST_LOAD: begin
        if (!out_valid || !out_stall) begin
          load        = 1'b1;
          clear_image = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  ids_calc #(
    .NW(TW)
  ) u_calc (
    .clk       (clk),
    .rst       (rst),
    .start     (calc_start),
    .abs_sum   (abs_sum),
    .square_sum(square_sum),
    .count     (finite_n),
    .stat      (calc_stat),
    .mean_value(calc_mean),
    .rms_value (calc_rms)
  );

  assign mean_sel = (finite_n == '0) ? '0 : calc_mean;
  assign rms_sel  = (finite_n == '0) ? '0 : calc_rms;

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      largest_difference <= best_difference;
      worst_column       <= best_column[11:0];
      worst_row          <= best_row[11:0];
      worst_lane         <= best_lane;
      outlier_total      <= CNT_W'(outlier_count);
      nonfinite_total    <= CNT_W'(nonfinite_count);
      channel_total      <= CNT_W'(total_q);
      mean_difference    <= mean_sel;
      rms_difference     <= rms_sel;
      within_tolerance   <= (nonfinite_count == '0) && (mean_sel <= mean_abs_tolerance) &&
                            (rms_sel <= rmse_tolerance) &&
                            (32'(outlier_count) <= 32'(max_outlier_count));
    end
  end

  `ASSERT_ALWAYS(a_nonfin_bound, nonfinite_count <= position_count, "nonfinite count exceeds position")
  `ASSERT_NEXT(a_accept_conv, in_valid && !in_stall, state == ST_CONV, "accepted word not converted")
  `ASSERT_NEXT(a_done_load, calc_stat.done, state == ST_LOAD, "divider result not loaded")
  `ASSERT_ALWAYS(a_calc_only_in_calc, !calc_stat.busy || state == ST_CALC, "divider busy outside calc")

endmodule

`default_nettype wire
